>>> hdl/xyb_pkg.sv
`default_nettype none

package xyb_pkg;

    // Item codes for the func field.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Frame kinds selected by a start item.
    typedef enum logic [2:0] {
        KIND_SHORT  = 3'd0,
        KIND_LONG   = 3'd1,
        KIND_EOT    = 3'd2,
        KIND_CAN    = 3'd3,
        KIND_HDR81  = 3'd4,
        KIND_YMODEM = 3'd5
    } kind_t;

    // Line bytes and block lengths.
    localparam logic [7:0]  BYTE_SOH   = 8'h01;
    localparam logic [7:0]  BYTE_STX   = 8'h02;
    localparam logic [7:0]  BYTE_EOT   = 8'h04;
    localparam logic [7:0]  BYTE_CAN   = 8'h18;
    localparam logic [7:0]  BYTE_HDR81 = 8'h81;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [10:0] SHORT_LEN  = 11'd128;
    localparam logic [10:0] LONG_LEN   = 11'd1024;

    // Most result items that one input item can cause.
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic       func;
        logic [2:0] block_kind;
        logic [7:0] block_number;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_in_run;
        logic       frame_end;
    } out_item_t;

    // All result items of one input item, slot 0 sent first.
    typedef struct packed {
        logic [1:0]                        count;
        out_item_t [MAX_RESULTS-1:0]       res;
    } burst_t;

    // Fold one byte into a CRC-16, MSB first, no reflection.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/xymodem_block_framer_unit.sv
`default_nettype none

// XMODEM/YMODEM block framer. Each input item is a frame start or one payload byte; the
// block turns it into zero to three line bytes on the result channel (header, payload
// byte, CRC-16 or sum trailer), the last of them marked with last_in_run and the one
// that closes a frame with frame_end. An item passes an input register and then a burst
// register that sends its bytes one per cycle while m_ready is high. The burst register
// has a single output port, so an item that causes bytes waits in the input register
// until the last byte of the burst before it is taken. Input is accepted while earlier
// bytes still wait on the output. crc_mode (reset 1) selects the CRC-16 trailer; the user
// must write it only while the block is idle; the block itself does not enforce this.
module xymodem_block_framer_unit import xyb_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic     crc_mode_reg;
    logic     in_vld_reg;
    in_item_t in_item_reg;
    burst_t   burst;
    logic     can_load;
    logic     advance;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            crc_mode_reg <= cfg_wr_data;
        end
    end

    // The held item moves on when it causes nothing or the serializer takes its burst.
    assign advance = in_vld_reg && ((burst.count == 2'd0) || can_load);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    xyb_framer_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .crc_mode (crc_mode_reg),
        .take     (advance),
        .item     (in_item_reg),
        .burst    (burst)
    );

    xyb_out_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && (burst.count != 2'd0)),
        .burst_in (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

>>> hdl/xyb_framer_core.sv
`default_nettype none

module xyb_framer_core import xyb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     crc_mode,
    input  wire logic     take,
    input  wire in_item_t item,
    output burst_t        burst
);

    logic        open_block_reg, open_block_next;
    logic [10:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_value_reg, crc_value_next;
    logic [7:0]  sum_value_reg, sum_value_next;

    logic [15:0] crc_fold_val;
    logic [7:0]  sum_fold_val;
    logic [7:0]  num_cpl;
    logic        is_long;

    assign crc_fold_val = crc_fold(crc_value_reg, item.data_byte);
    assign sum_fold_val = sum_value_reg + item.data_byte;
    assign num_cpl      = ~item.block_number;
    assign is_long      = (kind_t'(item.block_kind) == KIND_LONG);

    // Result items and next block state for the item in the input register.
    always_comb begin
        burst           = '0;
        open_block_next = open_block_reg;
        bytes_left_next = bytes_left_reg;
        crc_value_next  = crc_value_reg;
        sum_value_next  = sum_value_reg;
        if (item.func == FUNC_START) begin
            case (kind_t'(item.block_kind))
                KIND_SHORT, KIND_LONG, KIND_YMODEM: begin
                    open_block_next = 1'b1;
                    bytes_left_next = is_long ? LONG_LEN : SHORT_LEN;
                    crc_value_next  = '0;
                    sum_value_next  = '0;
                    burst.count     = 2'd3;
                    burst.res[0]    = '{is_long ? BYTE_STX : BYTE_SOH, 1'b0, 1'b0};
                    burst.res[1]    = '{item.block_number, 1'b0, 1'b0};
                    burst.res[2]    = '{num_cpl, 1'b1, 1'b0};
                end
                KIND_EOT: begin
                    open_block_next = 1'b0;
                    bytes_left_next = '0;
                    burst.count     = 2'd1;
                    burst.res[0]    = '{BYTE_EOT, 1'b1, 1'b1};
                end
                KIND_CAN: begin
                    open_block_next = 1'b0;
                    bytes_left_next = '0;
                    burst.count     = 2'd1;
                    burst.res[0]    = '{BYTE_CAN, 1'b1, 1'b1};
                end
                KIND_HDR81: begin
                    open_block_next = 1'b0;
                    bytes_left_next = '0;
                    burst.count     = 2'd3;
                    burst.res[0]    = '{BYTE_HDR81, 1'b0, 1'b0};
                    burst.res[1]    = '{item.block_number, 1'b0, 1'b0};
                    burst.res[2]    = '{num_cpl, 1'b1, 1'b1};
                end
                default: begin
                    // Unknown kinds are dropped without a trace.
                    burst.count = 2'd0;
                end
            endcase
        end else if (open_block_reg && (bytes_left_reg != '0)) begin
            crc_value_next  = crc_fold_val;
            sum_value_next  = sum_fold_val;
            bytes_left_next = bytes_left_reg - 11'd1;
            if (bytes_left_reg == 11'd1) begin
                // Last byte of the block: the trailer follows it.
                open_block_next = 1'b0;
                burst.res[0]    = '{item.data_byte, 1'b0, 1'b0};
                if (crc_mode) begin
                    burst.count  = 2'd3;
                    burst.res[1] = '{crc_fold_val[15:8], 1'b0, 1'b0};
                    burst.res[2] = '{crc_fold_val[7:0], 1'b1, 1'b1};
                end else begin
                    burst.count  = 2'd2;
                    burst.res[1] = '{sum_fold_val, 1'b1, 1'b1};
                end
            end else begin
                burst.count  = 2'd1;
                burst.res[0] = '{item.data_byte, 1'b1, 1'b0};
            end
        end
    end

    // Block state is committed when the item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_block_reg <= 1'b0;
            bytes_left_reg <= '0;
            crc_value_reg  <= '0;
            sum_value_reg  <= '0;
        end else if (take) begin
            open_block_reg <= open_block_next;
            bytes_left_reg <= bytes_left_next;
            crc_value_reg  <= crc_value_next;
            sum_value_reg  <= sum_value_next;
        end
    end

    // A block is open exactly while payload bytes remain.
    a_open_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        open_block_reg == (bytes_left_reg != '0))
        else $error("open flag and byte count disagree");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= LONG_LEN)
        else $error("byte count above the long block length");

    // The last payload byte always brings a trailer with a frame end.
    a_last_byte_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        (item.func == FUNC_DATA && open_block_reg && bytes_left_reg == 11'd1)
        |-> (burst.count >= 2'd2 && burst.res[burst.count - 2'd1].frame_end))
        else $error("last payload byte without trailer");

endmodule

`default_nettype wire

>>> hdl/xyb_out_serializer.sv
`default_nettype none

module xyb_out_serializer import xyb_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire burst_t    burst_in,
    output logic           can_load,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    burst_t     burst_reg;
    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic       idx_last;

    assign idx_last = (idx_reg == burst_reg.count - 2'd1);
    assign can_load = !vld_reg || (m_ready && idx_last);
    assign m_valid  = vld_reg;

    // Pick the result item that is on the line now.
    always_comb begin
        case (idx_reg)
            2'd0:    m_item = burst_reg.res[0];
            2'd1:    m_item = burst_reg.res[1];
            2'd2:    m_item = burst_reg.res[2];
            default: m_item = burst_reg.res[0];
        endcase
    end

    // Step through the burst; a new burst may follow its last item at once.
    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (load) begin
            idx_next = 2'd0;
            vld_next = 1'b1;
        end else if (vld_reg && m_ready) begin
            if (idx_last) begin
                vld_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst_in;
        end
    end

    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (burst_in.count != 2'd0))
        else $error("empty burst loaded");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (burst_reg.count != 2'd0 && idx_reg < burst_reg.count))
        else $error("result index outside the burst");

    // Only the final slot of a burst carries the run marker.
    a_last_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (m_item.last_in_run == idx_last))
        else $error("run marker on the wrong slot");

endmodule

`default_nettype wire
